[rtl/pswd_pkg.sv]
// ============================================================================
// pswd_pkg
// Shared types, constants and color expansion for the packed sprite word
// decoder.
// ============================================================================
package pswd_pkg;

    // Default width of the linear screen index counter
    localparam int INDEX_BITS_DEFAULT = 24;

    // Payload widths
    localparam int WORD_W   = 16;
    localparam int SINDEX_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PACKED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LINE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 2'd3;

    // Configuration reset values
    localparam logic        PACKED_MODE_RST = 1'b1;
    localparam logic [15:0] SCAN_LINE_RST   = 16'd320;
    localparam logic [8:0]  WIDTH_RST       = 9'd256;
    localparam logic [8:0]  HEIGHT_RST      = 9'd256;

    // Largest sprite dimension
    localparam logic [8:0]  DIM_MAX = 9'd256;

    // Color expansion constants (RGB565 to RGB888)
    localparam logic [15:0] RED_MASK   = 16'hF800;
    localparam logic [15:0] GREEN_MASK = 16'h07E0;
    localparam logic [15:0] BLUE_MASK  = 16'h001F;
    localparam logic [13:0] MUL5 = 14'd527;
    localparam logic [13:0] ADD5 = 14'd23;
    localparam logic [13:0] MUL6 = 14'd259;
    localparam logic [13:0] ADD6 = 14'd33;

    // Result word kinds
    typedef enum logic [2:0] {
        KIND_COUNT  = 3'd0,
        KIND_SKIP   = 3'd1,
        KIND_PCOUNT = 3'd2,
        KIND_PIXEL  = 3'd3,
        KIND_EXTRA  = 3'd4
    } pswd_kind_t;

    // One result item
    typedef struct packed {
        pswd_kind_t    word_kind;
        logic [23:0]   screen_index;
        logic [7:0]    pixel_row;
        logic [7:0]    pixel_col;
        logic          in_image;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic          image_done;
    } pswd_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic div_step;
        logic commit;
    } pswd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic needs_div;
    } pswd_stat_t;

    // Zero or oversize dimension reads as the maximum
    function automatic logic [8:0] dim(input logic [8:0] v);
        return (v == 9'd0 || v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    // 5-bit channel to 8 bits
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [13:0] p;
        p = 14'(c) * MUL5 + ADD5;
        return p[13:6];
    endfunction

    // 6-bit channel to 8 bits
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [13:0] p;
        p = 14'(c) * MUL6 + ADD6;
        return p[13:6];
    endfunction

endpackage

[rtl/pswd_if.sv]
// ============================================================================
// pswd_if
// Channel interfaces: data word input, result output, configuration writes.
// ============================================================================

// Input data word channel
interface pswd_word_if;
    logic        valid;
    logic        ready;
    logic [pswd_pkg::WORD_W-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

// Result channel
interface pswd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  word_kind;
    logic [pswd_pkg::SINDEX_W-1:0] screen_index;
    logic [7:0]  pixel_row;
    logic [7:0]  pixel_col;
    logic        in_image;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        image_done;

    modport source (output valid, output word_kind, output screen_index,
                    output pixel_row, output pixel_col, output in_image,
                    output red, output green, output blue, output image_done,
                    input ready);
    modport sink   (input valid, input word_kind, input screen_index,
                    input pixel_row, input pixel_col, input in_image,
                    input red, input green, input blue, input image_done,
                    output ready);
endinterface

// Configuration write channel
interface pswd_cfg_if;
    logic        valid;
    logic        ready;
    logic [pswd_pkg::CFG_IDX_W-1:0]  index;
    logic [pswd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pswd_ctrl.sv]
// ============================================================================
// pswd_ctrl
// Sequencer: accepts a word, runs the divider for pixel words, then commits
// the result into the output register when it is free.
// ============================================================================
module pswd_ctrl #(
    parameter int INDEX_BITS = pswd_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pswd_pkg::pswd_stat_t stat,
    output pswd_pkg::pswd_cmd_t  cmd
);

    localparam int CNT_W = $clog2(INDEX_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(INDEX_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;
    logic             accept;

    // Handshake and commands
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture  = accept;
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.commit   = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    end

    // State, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    count_reg <= '0;
                    if (accept)
                        state_reg <= stat.needs_div ? ST_DIVIDE : ST_COMMIT;
                end
                ST_DIVIDE:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == LAST_STEP)
                        state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (cmd.commit)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/pswd_datapath.sv]
// ============================================================================
// pswd_datapath
// Stream state, configuration registers, bit-serial divider for row and
// column, and the result register.
// ============================================================================
module pswd_datapath #(
    parameter int INDEX_BITS = pswd_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pswd_pkg::pswd_cmd_t                 cmd,
    output pswd_pkg::pswd_stat_t                stat,
    input  logic [pswd_pkg::WORD_W-1:0]         data_word,
    input  logic                                cfg_we,
    input  logic [pswd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pswd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output pswd_pkg::pswd_result_t              result
);

    localparam int IB = INDEX_BITS;
    localparam int CW = (IB > 17) ? IB : 17;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_SKIP,
        PH_PCOUNT,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    // Configuration
    logic        packed_mode_reg;
    logic [15:0] scan_line_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    // Stream state
    phase_t      phase_reg, phase_next;
    logic [16:0] chunks_reg, chunks_next;
    logic [15:0] pixels_reg, pixels_next;
    logic [IB-1:0] cursor_reg, cursor_next;
    logic [31:0] rec_reg, rec_next;

    // Captured word and divider
    logic [15:0]   word_reg;
    logic [15:0]   rem_reg;
    logic [IB-1:0] quo_reg;

    pswd_pkg::pswd_result_t res_reg, res_next;

    logic [8:0]    wd, ht;
    logic [16:0]   scan17, divisor;
    logic [16:0]   trial;
    logic          trial_ge;
    logic [16:0]   trial_diff;
    logic [16:0]   total;
    logic [14:0]   skip15;
    logic          skip_big;
    logic [15:0]   skip_rec;
    logic [15:0]   skip_add;
    logic [IB-1:0] cursor_skip, cursor_inc;
    logic [15:0]   pcount;
    logic [15:0]   pixels_dec;
    logic [16:0]   chunks_dec;
    logic          in_img;
    logic [IB+23:0] idx_ext;
    logic          unpacked_end;

    function automatic logic [IB-1:0] sat_add(input logic [IB-1:0] a,
                                              input logic [15:0] b);
        logic [IB:0] s;
        s = {1'b0, a} + (IB+1)'(b);
        return s[IB] ? '1 : s[IB-1:0];
    endfunction

    // Effective geometry
    assign wd      = pswd_pkg::dim(width_reg);
    assign ht      = pswd_pkg::dim(height_reg);
    assign scan17  = (scan_line_reg == 16'd0) ? 17'h10000 : {1'b0, scan_line_reg};
    assign divisor = packed_mode_reg ? scan17 : {8'd0, wd};
    assign total   = 17'(wd) * 17'(ht);

    assign stat.needs_div = (phase_reg != PH_DONE) &&
                            (!packed_mode_reg || phase_reg == PH_PIXELS);

    // Restoring divider step: one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[IB-1]};
    assign trial_ge   = (trial >= divisor);
    assign trial_diff = trial - divisor;

    // Skip word handling
    assign skip15      = word_reg[15:1];
    assign skip_big    = ({2'b00, skip15} > scan17);
    assign skip_rec    = {1'b0, skip15} + rec_reg[15:0];
    assign skip_add    = skip_big ? skip_rec : {1'b0, skip15};
    assign cursor_skip = sat_add(cursor_reg, skip_add);
    assign cursor_inc  = sat_add(cursor_reg, 16'd1);
    assign pcount      = word_reg + 16'd1;
    assign pixels_dec  = pixels_reg - 16'd1;
    assign chunks_dec  = chunks_reg - 17'd1;
    assign unpacked_end = (CW'(cursor_inc) >= CW'(total));

    // Pixel geometry from the divider result
    assign in_img  = (quo_reg < IB'(ht)) && (rem_reg < 16'(wd));
    assign idx_ext = {24'd0, cursor_reg};

    // Next stream state and result
    always_comb
    begin
        phase_next  = phase_reg;
        chunks_next = chunks_reg;
        pixels_next = pixels_reg;
        cursor_next = cursor_reg;
        rec_next    = rec_reg;
        res_next    = '0;
        res_next.word_kind = pswd_pkg::KIND_EXTRA;

        if (phase_reg != PH_DONE && (!packed_mode_reg || phase_reg == PH_PIXELS))
        begin
            res_next.word_kind    = pswd_pkg::KIND_PIXEL;
            res_next.screen_index = idx_ext[23:0];
            res_next.in_image     = in_img;
            res_next.pixel_row    = in_img ? quo_reg[7:0] : 8'd0;
            res_next.pixel_col    = in_img ? rem_reg[7:0] : 8'd0;
            res_next.red   = pswd_pkg::expand5(word_reg[15:11]);
            res_next.green = pswd_pkg::expand6(word_reg[10:5]);
            res_next.blue  = pswd_pkg::expand5(word_reg[4:0]);
            cursor_next    = cursor_inc;
        end

        if (phase_reg == PH_DONE)
        begin
            res_next.word_kind = pswd_pkg::KIND_EXTRA;
        end
        else if (!packed_mode_reg)
        begin
            if (unpacked_end)
            begin
                phase_next          = PH_DONE;
                res_next.image_done = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    res_next.word_kind = pswd_pkg::KIND_COUNT;
                    chunks_next        = {1'b0, word_reg} + 17'd1;
                    phase_next         = PH_SKIP;
                end
                PH_SKIP:
                begin
                    res_next.word_kind = pswd_pkg::KIND_SKIP;
                    rec_next    = skip_big ? 32'd0 : rec_reg + 32'(skip15);
                    cursor_next = cursor_skip;
                    phase_next  = PH_PCOUNT;
                end
                PH_PCOUNT:
                begin
                    res_next.word_kind = pswd_pkg::KIND_PCOUNT;
                    pixels_next = pcount;
                    rec_next    = rec_reg + 32'(pcount);
                    if (pcount == 16'd0)
                    begin
                        chunks_next = chunks_dec;
                        if (chunks_dec == 17'd0)
                        begin
                            phase_next          = PH_DONE;
                            res_next.image_done = 1'b1;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                    else
                        phase_next = PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    pixels_next = pixels_dec;
                    if (pixels_dec == 16'd0)
                    begin
                        chunks_next = chunks_dec;
                        if (chunks_dec == 17'd0)
                        begin
                            phase_next          = PH_DONE;
                            res_next.image_done = 1'b1;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                end
                default:
                begin
                    res_next.word_kind = pswd_pkg::KIND_EXTRA;
                end
            endcase
        end
    end

    // Configuration and stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packed_mode_reg <= pswd_pkg::PACKED_MODE_RST;
            scan_line_reg   <= pswd_pkg::SCAN_LINE_RST;
            width_reg       <= pswd_pkg::WIDTH_RST;
            height_reg      <= pswd_pkg::HEIGHT_RST;
            phase_reg       <= PH_COUNT;
            chunks_reg      <= '0;
            pixels_reg      <= '0;
            cursor_reg      <= '0;
            rec_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pswd_pkg::CFG_PACKED_MODE: packed_mode_reg <= cfg_data[0];
                    pswd_pkg::CFG_SCAN_LINE:   scan_line_reg   <= cfg_data;
                    pswd_pkg::CFG_WIDTH:       width_reg       <= cfg_data[8:0];
                    pswd_pkg::CFG_HEIGHT:      height_reg      <= cfg_data[8:0];
                    default:                   packed_mode_reg <= packed_mode_reg;
                endcase
            end
            if (cmd.commit)
            begin
                phase_reg  <= phase_next;
                chunks_reg <= chunks_next;
                pixels_reg <= pixels_next;
                cursor_reg <= cursor_next;
                rec_reg    <= rec_next;
            end
        end
    end

    // Captured word, divider and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg <= data_word;
            quo_reg  <= cursor_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[IB-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_diff[15:0] : trial[15:0];
        end
        if (cmd.commit)
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

[rtl/packed_sprite_word_decoder_unit.sv]
// ============================================================================
// packed_sprite_word_decoder_unit
// Decodes a stream of 16-bit sprite image words into one result per word.
// ============================================================================
// Usage:
//   words   : one big-endian image data word per transfer (valid/ready).
//   results : one result per accepted word: its kind, and for pixel words
//             the screen index, row/column, crop flag and RGB888 color.
//   cfg     : register writes (index, data), always ready; write only while
//             no word is in flight.
// Sequencing:
//   Count, skip and pixel-count words: no division; the word passes from
//   the accept state to the commit state.
//   Pixel words: row and column come from a restoring divider that yields
//   one quotient bit per cycle, and the result is committed when it ends.
//   One word is decoded at a time; the next word is taken while the
//   previous result waits in the output register.
// Reset: configuration returns to packed mode, scan line 320, 256 x 256;
//   the decoder expects a chunk count word. No clearing pass.
// Stall: while results.ready is low the finished result holds, one more
//   word is decoded and then held until the output register frees.
// ============================================================================
module packed_sprite_word_decoder_unit #(
    parameter int INDEX_BITS = pswd_pkg::INDEX_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    pswd_word_if.sink      words,
    pswd_result_if.source  results,
    pswd_cfg_if.sink       cfg
);

    pswd_pkg::pswd_cmd_t    cmd;
    pswd_pkg::pswd_stat_t   stat;
    pswd_pkg::pswd_result_t result;

    assign cfg.ready = 1'b1;

    pswd_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (words.valid),
        .in_ready  (words.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pswd_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .data_word (words.data_word),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .result    (result)
    );

    // Result fields
    assign results.word_kind    = result.word_kind;
    assign results.screen_index = result.screen_index;
    assign results.pixel_row    = result.pixel_row;
    assign results.pixel_col    = result.pixel_col;
    assign results.in_image     = result.in_image;
    assign results.red          = result.red;
    assign results.green        = result.green;
    assign results.blue         = result.blue;
    assign results.image_done   = result.image_done;

    // One word in flight: no transfer right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && words.ready |=> !words.ready)
        else $error("input taken on consecutive cycles");

    // Only pixel results carry geometry
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.word_kind != pswd_pkg::KIND_PIXEL |->
            !results.in_image && results.screen_index == '0)
        else $error("geometry on a non-pixel result");

    // Image end comes only on a pixel or pixel count word
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.image_done |->
            results.word_kind == pswd_pkg::KIND_PIXEL ||
            results.word_kind == pswd_pkg::KIND_PCOUNT)
        else $error("image end on wrong word kind");

    // Row and column stay zero outside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.in_image |->
            results.pixel_row == 8'd0 && results.pixel_col == 8'd0)
        else $error("row or column set outside the image");

endmodule

[tb/sv/tb.sv]
// ============================================================================
// tb
// Self-checking testbench for packed_sprite_word_decoder_unit. One image
// stream runs from reset to completion. It has corner chunks under the reset
// layout and a switch to sequential pixels in the middle of a run. Random
// chunks follow over a sweep of scan line and crop settings, then a long run
// of maximal skips that saturates the screen cursor. The image is finished in
// chunked or sequential mode, chosen at random, and words are sent past the
// end. An in-bench decoder predicts every result, and the results are
// compared field by field under random idling on both channels.
// ============================================================================
module tb;

    localparam int INDEX_W = pswd_pkg::INDEX_BITS_DEFAULT;
    localparam longint unsigned POS_MAX = (64'd1 << INDEX_W) - 1;
    // Leave margin after a drain
    localparam int SETTLE_CYCLES = INDEX_W + 8;
    localparam int CYCLE_LIMIT = 800000;

    // Chunk budget of the single image stream
    localparam int DIRECTED_CHUNKS = 4;
    localparam int SWEEP_SETTINGS = 5;
    localparam int CHUNKS_PER_SETTING = 12;
    localparam int LONG_CHUNKS = 515;
    localparam int TAIL_CHUNKS = 3;
    localparam int TOTAL_CHUNKS = DIRECTED_CHUNKS + SWEEP_SETTINGS * CHUNKS_PER_SETTING
                                  + LONG_CHUNKS + TAIL_CHUNKS + 1;

    typedef enum logic [2:0] {
        WAIT_COUNT,
        WAIT_SKIP,
        WAIT_PCOUNT,
        IN_RUN,
        FINISHED
    } stream_phase_e;

    logic clk = 1'b0;
    logic rst_n;

    pswd_word_if   words();
    pswd_result_if results();
    pswd_cfg_if    cfg();

    packed_sprite_word_decoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words),
        .results (results),
        .cfg     (cfg)
    );

    // Clock: period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Register shadow
    bit          mode_packed = pswd_pkg::PACKED_MODE_RST;
    logic [15:0] line_len    = pswd_pkg::SCAN_LINE_RST;
    logic [8:0]  img_w       = pswd_pkg::WIDTH_RST;
    logic [8:0]  img_h       = pswd_pkg::HEIGHT_RST;

    // Decoder state
    stream_phase_e   phase_q    = WAIT_COUNT;
    logic [16:0]     chunks_rem = '0;
    logic [15:0]     run_rem    = '0;
    logic [31:0]     recorded   = '0;
    longint unsigned screen_pos = 0;

    logic [15:0]            word_backlog[$];
    pswd_pkg::pswd_result_t pending_results[$];

    bit no_idle = 1'b0;
    int word_gap = 0;
    int sink_stall = 0;
    int mismatches = 0;
    int words_fed = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    // Cursor advance, saturating at the index width
    function automatic longint unsigned bump_pos(input longint unsigned n);
        return (screen_pos + n > POS_MAX) ? POS_MAX : screen_pos + n;
    endfunction

    // One chunk finished; returns 1 when it was the last one
    function automatic logic close_chunk();
        chunks_rem = chunks_rem - 17'd1;
        if (chunks_rem == 17'd0)
        begin
            phase_q = FINISHED;
            return 1'b1;
        end
        phase_q = WAIT_SKIP;
        return 1'b0;
    endfunction

    // Expected result of one data word; advances the decoder state
    function automatic pswd_pkg::pswd_result_t decode_word(input logic [15:0] w);
        pswd_pkg::pswd_result_t r;
        longint unsigned wd;
        longint unsigned ht;
        longint unsigned line;
        longint unsigned row;
        longint unsigned col;
        longint unsigned skip;
        r = '0;
        wd = (img_w == 9'd0 || img_w > 9'd256) ? 64'd256 : 64'(img_w);
        ht = (img_h == 9'd0 || img_h > 9'd256) ? 64'd256 : 64'(img_h);
        line = (line_len == 16'd0) ? 64'd65536 : 64'(line_len);

        if (phase_q == FINISHED)
        begin
            r.word_kind = pswd_pkg::KIND_EXTRA;
            return r;
        end

        // Pixel word: sequential mode reads every word as one
        if (!mode_packed || phase_q == IN_RUN)
        begin
            r.word_kind = pswd_pkg::KIND_PIXEL;
            r.screen_index = 24'(screen_pos);
            if (mode_packed)
            begin
                row = screen_pos / line;
                col = screen_pos % line;
            end
            else
            begin
                row = screen_pos / wd;
                col = screen_pos % wd;
            end
            if (col < wd && row < ht)
            begin
                r.pixel_row = 8'(row);
                r.pixel_col = 8'(col);
                r.in_image = 1'b1;
            end
            r.red   = 8'((32'(w[15:11]) * 527 + 23) >> 6);
            r.green = 8'((32'(w[10:5]) * 259 + 33) >> 6);
            r.blue  = 8'((32'(w[4:0]) * 527 + 23) >> 6);
            screen_pos = bump_pos(1);
            if (!mode_packed)
            begin
                if (screen_pos >= wd * ht)
                begin
                    phase_q = FINISHED;
                    r.image_done = 1'b1;
                end
            end
            else
            begin
                run_rem = run_rem - 16'd1;
                if (run_rem == 16'd0)
                    r.image_done = close_chunk();
            end
            return r;
        end

        case (phase_q)
            WAIT_COUNT:
            begin
                r.word_kind = pswd_pkg::KIND_COUNT;
                chunks_rem = 17'(w) + 17'd1;
                phase_q = WAIT_SKIP;
            end
            WAIT_SKIP:
            begin
                // Bytes to pixels; a skip past the line folds in the recorded total
                r.word_kind = pswd_pkg::KIND_SKIP;
                skip = 64'(w >> 1);
                if (skip > line)
                begin
                    skip = (skip + 64'(recorded)) & 64'hFFFF;
                    recorded = '0;
                end
                else
                    recorded = recorded + 32'(skip);
                screen_pos = bump_pos(skip);
                phase_q = WAIT_PCOUNT;
            end
            default:
            begin
                r.word_kind = pswd_pkg::KIND_PCOUNT;
                run_rem = w + 16'd1;
                recorded = recorded + 32'(run_rem);
                if (run_rem == 16'd0)
                    r.image_done = close_chunk();
                else
                    phase_q = IN_RUN;
            end
        endcase
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        pswd_pkg::pswd_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result transfer with no word outstanding (kind %0d)",
                   results.word_kind);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        cmp_field("word_kind",    32'(want.word_kind),    32'(results.word_kind));
        cmp_field("screen_index", 32'(want.screen_index), 32'(results.screen_index));
        cmp_field("pixel_row",    32'(want.pixel_row),    32'(results.pixel_row));
        cmp_field("pixel_col",    32'(want.pixel_col),    32'(results.pixel_col));
        cmp_field("in_image",     32'(want.in_image),     32'(results.in_image));
        cmp_field("red",          32'(want.red),          32'(results.red));
        cmp_field("green",        32'(want.green),        32'(results.green));
        cmp_field("blue",         32'(want.blue),         32'(results.blue));
        cmp_field("image_done",   32'(want.image_done),   32'(results.image_done));
    endtask

    // Word driver: predicts on every transfer, then gaps or sends the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words.valid <= 1'b0;
            words.data_word <= '0;
            word_gap = 0;
        end
        else
        begin
            if (words.valid && words.ready)
            begin
                pending_results.push_back(decode_word(words.data_word));
                words_fed++;
                word_gap = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (!words.valid || words.ready)
            begin
                if (word_gap > 0)
                begin
                    words.valid <= 1'b0;
                    word_gap--;
                end
                else if (word_backlog.size() > 0)
                begin
                    words.valid <= 1'b1;
                    words.data_word <= word_backlog.pop_front();
                end
                else
                    words.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                check_result();
                sink_stall = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (sink_stall > 0)
            begin
                results.ready <= 1'b0;
                sink_stall--;
            end
            else
                results.ready <= 1'b1;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Register write; only called with the stream drained
    task automatic write_reg(input logic [pswd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        reg_writes++;
        case (idx)
            pswd_pkg::CFG_PACKED_MODE: mode_packed = value[0];
            pswd_pkg::CFG_SCAN_LINE:   line_len = value;
            pswd_pkg::CFG_WIDTH:       img_w = value[8:0];
            pswd_pkg::CFG_HEIGHT:      img_h = value[8:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Sender holds off until every result is back, then lets the block settle
    task automatic wait_drained();
        while (word_backlog.size() != 0 || words.valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_chunk(input logic [15:0] skip_w, input logic [15:0] count_w,
                             input int n_px);
        word_backlog.push_back(skip_w);
        word_backlog.push_back(count_w);
        repeat (n_px) word_backlog.push_back(rand_pixel());
    endtask

    // Random chunk: skips mostly around the scan line, short runs, some empty
    task automatic rand_chunk();
        int          span;
        int          pick;
        logic [15:0] skip_w;
        logic [15:0] count_w;
        span = 2 * ((line_len == 16'd0) ? 65536 : int'(line_len)) + 3;
        if (span > 65535)
            span = 65535;
        skip_w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
        pick = $urandom_range(0, 19);
        if (pick < 3)
            count_w = 16'hFFFF;
        else if (pick == 3)
            count_w = 16'($urandom_range(7, 39));
        else
            count_w = 16'($urandom_range(0, 6));
        add_chunk(skip_w, count_w, int'(16'(count_w + 16'd1)));
    endtask

    // Stimulus
    initial
    begin
        int lines[SWEEP_SETTINGS];
        int widths[SWEEP_SETTINGS];
        int heights[SWEEP_SETTINGS];
        int s;
        int n;
        bit end_packed;

        lines   = '{600, 65535, 1, 40, 0};
        widths  = '{256, 256, 1, 300, 0};
        heights = '{256, 256, 1, 3, 0};

        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = pswd_pkg::CFG_PACKED_MODE;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: chunk count, pure colors, skip equal to and past the
        // scan line, an empty run, then a run cut by a mode switch
        word_backlog.push_back(16'(TOTAL_CHUNKS - 1));
        add_chunk(16'h0000, 16'h0004, 0);
        word_backlog.push_back(16'h0000);
        word_backlog.push_back(16'hFFFF);
        word_backlog.push_back(16'hF800);
        word_backlog.push_back(16'h07E0);
        word_backlog.push_back(16'h001F);
        add_chunk(16'h0281, 16'hFFFF, 0);
        add_chunk(16'h0284, 16'h0000, 0);
        word_backlog.push_back(16'hA5A5);
        add_chunk(16'h0201, 16'h0004, 0);
        word_backlog.push_back(16'h1234);
        word_backlog.push_back(16'h5A5A);

        // Sequential pixels in the middle of a chunked run
        wait_drained();
        write_reg(pswd_pkg::CFG_PACKED_MODE, 16'd0);
        repeat (20) word_backlog.push_back(rand_pixel());
        wait_drained();
        write_reg(pswd_pkg::CFG_WIDTH, 16'd0);
        write_reg(pswd_pkg::CFG_HEIGHT, 16'd300);
        no_idle = 1'b1;
        repeat (20) word_backlog.push_back(rand_pixel());
        wait_drained();
        write_reg(pswd_pkg::CFG_PACKED_MODE, 16'd1);
        write_reg(pswd_pkg::CFG_WIDTH, 16'd256);
        write_reg(pswd_pkg::CFG_HEIGHT, 16'd256);
        no_idle = 1'b0;
        repeat (3) word_backlog.push_back(rand_pixel());

        // Random chunks over a sweep of layouts; the last one is random
        for (s = 0; s < SWEEP_SETTINGS; s++)
        begin
            wait_drained();
            if (s == SWEEP_SETTINGS - 1)
            begin
                lines[s] = $urandom_range(1, 1000);
                widths[s] = $urandom_range(1, 256);
                heights[s] = $urandom_range(1, 256);
            end
            write_reg(pswd_pkg::CFG_SCAN_LINE, 16'(lines[s]));
            write_reg(pswd_pkg::CFG_WIDTH, 16'(widths[s]));
            write_reg(pswd_pkg::CFG_HEIGHT, 16'(heights[s]));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (CHUNKS_PER_SETTING)
            begin
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
                rand_chunk();
            end
        end

        // Empty chunks with maximal skips push the cursor into saturation
        wait_drained();
        write_reg(pswd_pkg::CFG_SCAN_LINE, 16'd0);
        write_reg(pswd_pkg::CFG_WIDTH, 16'd256);
        write_reg(pswd_pkg::CFG_HEIGHT, 16'd256);
        no_idle = ($urandom_range(0, 1) == 0);
        repeat (LONG_CHUNKS)
            add_chunk(16'hFFFE | 16'($urandom_range(0, 1)), 16'hFFFF, 0);

        // A few runs at the saturated cursor
        wait_drained();
        write_reg(pswd_pkg::CFG_SCAN_LINE, 16'($urandom_range(1, 65535)));
        write_reg(pswd_pkg::CFG_WIDTH, 16'($urandom_range(1, 256)));
        write_reg(pswd_pkg::CFG_HEIGHT, 16'($urandom_range(1, 256)));
        no_idle = 1'b0;
        repeat (TAIL_CHUNKS) rand_chunk();

        // Finish the image: last chunk, or sequential mode past the crop area
        wait_drained();
        end_packed = $urandom_range(0, 1);
        if (end_packed)
        begin
            if ($urandom_range(0, 1))
                add_chunk(16'($urandom), 16'hFFFF, 0);
            else
            begin
                n = $urandom_range(1, 4);
                add_chunk(16'($urandom), 16'(n - 1), n);
            end
        end
        else
        begin
            write_reg(pswd_pkg::CFG_PACKED_MODE, 16'd0);
            write_reg(pswd_pkg::CFG_WIDTH, 16'($urandom_range(1, 256)));
            write_reg(pswd_pkg::CFG_HEIGHT, 16'($urandom_range(1, 256)));
            word_backlog.push_back(rand_pixel());
        end

        // Words after completion, in both modes
        repeat (8) word_backlog.push_back(rand_pixel());
        wait_drained();
        write_reg(pswd_pkg::CFG_PACKED_MODE, end_packed ? 16'd0 : 16'd1);
        repeat (8) word_backlog.push_back(rand_pixel());
        wait_drained();

        $display("Fed %0d words, checked %0d results, %0d register writes.",
                 words_fed, results_seen, reg_writes);
        $display("Covered chunked and sequential layouts, cursor saturation, %s ending.",
                 end_packed ? "chunked" : "sequential");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
